@@ rtl/solid_gradient_noise_3d_assert.svh @@
// Assertion macros shared by the gradient noise RTL.
`ifndef SOLID_GRADIENT_NOISE_3D_ASSERT_SVH
`define SOLID_GRADIENT_NOISE_3D_ASSERT_SVH
// Same-cycle implication, gated off during reset.
`define SGN3D_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, gated off during reset.
`define SGN3D_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ rtl/sgn3d_pkg.sv @@
// Shared types, constants and helper functions for the gradient noise block.
package sgn3d_pkg;

   localparam logic [63:0] PERM_RESET = 64'hFEDCBA9876543210;
   localparam int          NUM_STAGES = 10;

   typedef logic signed [11:0] cell_type;
   typedef logic        [11:0] frac_type;
   typedef logic        [12:0] mag_type;
   typedef logic        [16:0] wgt_type;
   typedef logic signed [14:0] dot_type;
   typedef logic        [3:0]  nib_type;

   localparam logic signed [1:0] GRAD_X [16] = '{
      2'b01, 2'b11, 2'b01, 2'b11, 2'b01, 2'b11, 2'b01, 2'b11,
      2'b00, 2'b00, 2'b00, 2'b00, 2'b01, 2'b11, 2'b00, 2'b00};
   localparam logic signed [1:0] GRAD_Y [16] = '{
      2'b01, 2'b01, 2'b11, 2'b11, 2'b00, 2'b00, 2'b00, 2'b00,
      2'b01, 2'b11, 2'b01, 2'b11, 2'b01, 2'b01, 2'b11, 2'b11};
   localparam logic signed [1:0] GRAD_Z [16] = '{
      2'b00, 2'b00, 2'b00, 2'b00, 2'b01, 2'b01, 2'b11, 2'b11,
      2'b01, 2'b01, 2'b11, 2'b11, 2'b00, 2'b00, 2'b01, 2'b11};

   // Permutation entry at |n| mod 16.
   function automatic nib_type perm_pick(input logic [63:0] perm, input logic signed [13:0] n);
      nib_type m;
      m = n[13] ? 4'(4'd0 - n[3:0]) : n[3:0];
      return perm[{m, 2'b00} +: 4];
   endfunction

   // One gradient component times an offset.
   function automatic dot_type grad_term(input logic signed [1:0] g,
                                         input logic signed [12:0] off);
      dot_type r;
      unique case (g)
         2'b01:   r = 15'(off);
         2'b11:   r = -15'(off);
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/sgn3d_falloff.sv @@
// Four-stage falloff w(t) = 1 - 10t^3 + 15t^4 - 6t^5, rounded to Q.16.
module sgn3d_falloff
   import sgn3d_pkg::*;
(
   input  logic       clock,
   input  logic [3:0] en_i,
   input  mag_type    a_i,
   output wgt_type    w_o
);

   mag_type      a_ff;
   logic [24:0]  sq_ff;
   logic [36:0]  a3_ff;
   logic [27:0]  poly_ff;
   logic [46:0]  phi_ff;
   logic [45:0]  plo_ff;
   wgt_type      w_ff;

   logic [37:0]  sq_full;
   logic [37:0]  a3_full;
   logic [29:0]  poly_full;
   logic [60:0]  prod;
   logic [60:0]  wfull;

   assign sq_full   = 38'(a_i) * 38'(a_i);
   assign a3_full   = 38'(sq_ff) * 38'(a_ff);
   assign poly_full = 30'd167772160 + 30'(sq_ff) * 30'd6 - 30'(a_ff) * 30'd61440;
   assign prod      = (61'(phi_ff) << 18) + 61'(plo_ff);
   assign wfull     = 61'h1000_0800_0000_0000 - prod;

   always_ff @(posedge clock) begin
      if (en_i[0]) begin
         a_ff  <= a_i;
         sq_ff <= sq_full[24:0];
      end
      if (en_i[1]) begin
         a3_ff   <= a3_full[36:0];
         poly_ff <= poly_full[27:0];
      end
      if (en_i[2]) begin
         phi_ff <= 47'(a3_ff[36:18]) * 47'(poly_ff);
         plo_ff <= 46'(a3_ff[17:0]) * 46'(poly_ff);
      end
      if (en_i[3]) begin
         w_ff <= wfull[60:44];
      end
   end

   assign w_o = w_ff;

endmodule

@@ rtl/sgn3d_hash.sv @@
// Four-stage corner hash through the permutation and gradient dot products.
module sgn3d_hash
   import sgn3d_pkg::*;
(
   input  logic        clock,
   input  logic [3:0]  en_i,
   input  logic [63:0] perm_i,
   input  logic [23:0] x_i,
   input  logic [23:0] y_i,
   input  logic [23:0] z_i,
   output dot_type     dot_o [8]
);

   cell_type cx0_ff, cy0_ff, cx1_ff;
   frac_type fr0_ff [3];
   frac_type fr1_ff [3];
   frac_type fr2_ff [3];
   nib_type  gz0_ff [2];
   nib_type  gy1_ff [2][2];
   nib_type  g2_ff  [8];
   dot_type  dot3_ff [8];

   always_ff @(posedge clock) begin
      if (en_i[0]) begin
         cx0_ff    <= x_i[23:12];
         cy0_ff    <= y_i[23:12];
         fr0_ff[0] <= x_i[11:0];
         fr0_ff[1] <= y_i[11:0];
         fr0_ff[2] <= z_i[11:0];
      end
      if (en_i[1]) begin
         cx1_ff <= cx0_ff;
         fr1_ff <= fr0_ff;
      end
      if (en_i[2]) begin
         fr2_ff <= fr1_ff;
      end
   end

   for (genvar bz = 0; bz < 2; bz++) begin : g_z
      logic signed [13:0] nz;
      assign nz = 14'(signed'(z_i[23:12])) + 14'(bz);
      always_ff @(posedge clock) begin
         if (en_i[0]) gz0_ff[bz] <= perm_pick(perm_i, nz);
      end
      for (genvar by = 0; by < 2; by++) begin : g_y
         logic signed [13:0] ny;
         assign ny = 14'(cy0_ff) + 14'(by) + 14'(gz0_ff[bz]);
         always_ff @(posedge clock) begin
            if (en_i[1]) gy1_ff[bz][by] <= perm_pick(perm_i, ny);
         end
      end
   end

   for (genvar c = 0; c < 8; c++) begin : g_corner
      localparam int BX = c % 2;
      localparam int BY = (c / 2) % 2;
      localparam int BZ = c / 4;
      logic signed [13:0] nx;
      logic signed [12:0] ox, oy, oz;
      dot_type            dot_in;
      assign nx = 14'(cx1_ff) + 14'(BX) + 14'(gy1_ff[BZ][BY]);
      assign ox = (BX != 0) ? 13'({1'b0, fr2_ff[0]}) - 13'd4096 : 13'({1'b0, fr2_ff[0]});
      assign oy = (BY != 0) ? 13'({1'b0, fr2_ff[1]}) - 13'd4096 : 13'({1'b0, fr2_ff[1]});
      assign oz = (BZ != 0) ? 13'({1'b0, fr2_ff[2]}) - 13'd4096 : 13'({1'b0, fr2_ff[2]});
      assign dot_in = grad_term(GRAD_X[g2_ff[c]], ox) + grad_term(GRAD_Y[g2_ff[c]], oy)
                    + grad_term(GRAD_Z[g2_ff[c]], oz);
      always_ff @(posedge clock) begin
         if (en_i[2]) g2_ff[c]   <= perm_pick(perm_i, nx);
         if (en_i[3]) dot3_ff[c] <= dot_in;
      end
      assign dot_o[c] = dot3_ff[c];
   end

endmodule

@@ rtl/solid_gradient_noise_3d.sv @@
// A req transfer passes through stages 0..9 in order before rsp_tvalid rises with an idle output.
// One transfer per cycle while the output is not stalled; ten stages, each with its own valid bit.
// A stage loads whenever it is empty or the stage after it moves, so empty
// slots close up and input keeps flowing while a finished result waits.
// Reset (synchronous, active high) clears all valid bits and sets the
// permutation register to identity; the datapath registers are not reset.
`include "solid_gradient_noise_3d_assert.svh"
module solid_gradient_noise_3d
   import sgn3d_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,    // coord_x[23:0], coord_y[47:24], coord_z[71:48]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // noise_value[19:0], zero pad[23:20]
   input  logic        csr_wr_en,
   input  logic [63:0] csr_wr_data   // permutation_nibbles
);

   logic [63:0]           perm_ff;
   logic [NUM_STAGES-1:0] v_ff;
   logic [NUM_STAGES-1:0] en;

   // Stage k loads when empty or when stage k+1 loads; output stage on transfer.
   always_comb begin
      en[NUM_STAGES-1] = ~v_ff[NUM_STAGES-1] | rsp_tready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         en[k] = ~v_ff[k] | en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff    <= '0;
         perm_ff <= PERM_RESET;
      end else begin
         if (csr_wr_en) perm_ff <= csr_wr_data;
         if (en[0]) v_ff[0] <= req_tvalid;
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (en[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   assign req_tready = en[0];
   assign rsp_tvalid = v_ff[NUM_STAGES-1];

   // Stages 0..3: per-axis falloff for both corner offsets (frac and 1-frac).
   wgt_type wt3 [3][2];
   for (genvar ax = 0; ax < 3; ax++) begin : g_ax
      for (genvar b = 0; b < 2; b++) begin : g_b
         mag_type a_in;
         assign a_in = (b != 0) ? 13'd4096 - 13'(req_tdata[24*ax +: 12])
                                : 13'(req_tdata[24*ax +: 12]);
         sgn3d_falloff u_falloff (
            .clock (clock),
            .en_i  (en[3:0]),
            .a_i   (a_in),
            .w_o   (wt3[ax][b])
         );
      end
   end

   // Stages 0..3: gradient selection and dot products for the eight corners.
   dot_type dot3 [8];
   sgn3d_hash u_hash (
      .clock  (clock),
      .en_i   (en[3:0]),
      .perm_i (perm_ff),
      .x_i    (req_tdata[23:0]),
      .y_i    (req_tdata[47:24]),
      .z_i    (req_tdata[71:48]),
      .dot_o  (dot3)
   );

   // Stage 4: wx*wy for the four xy corner pairs.
   logic [33:0] mxy4_ff [2][2];
   wgt_type     wz4_ff  [2];
   dot_type     dot4_ff [8];
   for (genvar bx = 0; bx < 2; bx++) begin : g_mxy
      for (genvar by = 0; by < 2; by++) begin : g_mxy_y
         always_ff @(posedge clock) begin
            if (en[4]) mxy4_ff[bx][by] <= 34'(wt3[0][bx]) * 34'(wt3[1][by]);
         end
      end
   end
   always_ff @(posedge clock) begin
      if (en[4]) begin
         wz4_ff[0] <= wt3[2][0];
         wz4_ff[1] <= wt3[2][1];
         dot4_ff   <= dot3;
      end
   end

   // Stages 5..6: round, times wz, round, times dot.
   logic [33:0]        prod5_ff [8];
   dot_type            dot5_ff  [8];
   logic signed [31:0] term6_ff [8];
   for (genvar c = 0; c < 8; c++) begin : g_wt
      localparam int BX = c % 2;
      localparam int BY = (c / 2) % 2;
      localparam int BZ = c / 4;
      logic [33:0]        r5, r6;
      wgt_type            wxy, wt;
      logic signed [32:0] tp;
      assign r5  = mxy4_ff[BX][BY] + 34'd32768;
      assign wxy = r5[32:16];
      assign r6  = prod5_ff[c] + 34'd32768;
      assign wt  = r6[32:16];
      assign tp  = 33'(signed'({1'b0, wt})) * 33'(dot5_ff[c]);
      always_ff @(posedge clock) begin
         if (en[5]) begin
            prod5_ff[c] <= 34'(wxy) * 34'(wz4_ff[BZ]);
            dot5_ff[c]  <= dot4_ff[c];
         end
         if (en[6]) term6_ff[c] <= tp[31:0];
      end
   end

   // Stages 7..8: adder tree over the eight corner terms.
   logic signed [32:0] s7_ff [4];
   logic signed [34:0] sum8_ff;
   for (genvar k = 0; k < 4; k++) begin : g_s7
      always_ff @(posedge clock) begin
         if (en[7]) s7_ff[k] <= 33'(term6_ff[2*k]) + 33'(term6_ff[2*k+1]);
      end
   end
   always_ff @(posedge clock) begin
      if (en[8]) sum8_ff <= 35'(s7_ff[0]) + 35'(s7_ff[1]) + 35'(s7_ff[2]) + 35'(s7_ff[3]);
   end

   // Stage 9: round half up to Q.16 and saturate into the output register.
   logic signed [34:0] rnd;
   logic signed [19:0] out_in;
   logic signed [19:0] out_ff;
   assign rnd = (sum8_ff + 35'sd2048) >>> 12;
   always_comb begin
      priority if (rnd > 35'sd524287) begin
         out_in = 20'sd524287;
      end else if (rnd < -35'sd524288) begin
         out_in = -20'sd524288;
      end else begin
         out_in = rnd[19:0];
      end
   end
   always_ff @(posedge clock) begin
      if (en[9]) out_ff <= out_in;
   end

   assign rsp_tdata = {4'b0000, out_ff};

   // An empty output stage must let a new transfer in.
   `SGN3D_ASSERT_NOW(a_open_when_drained, clock, reset, !v_ff[NUM_STAGES-1], req_tready, "input stalled with empty output stage")
   // An accepted transfer occupies the first stage.
   `SGN3D_ASSERT_NEXT(a_accept_lands, clock, reset, req_tvalid && req_tready, v_ff[0], "accepted transfer lost at stage 0")
   // Occupancy grows by at most one item per cycle.
   `SGN3D_ASSERT_NEXT(a_fill_rate, clock, reset, 1'b1, $countones(v_ff) <= $past($countones(v_ff)) + 1, "pipeline occupancy jumped")

endmodule
